### design/pidc_pkg.sv
package pidc_pkg;

    // fixed point format and datapath widths
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 31;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int INTEG_W   = TERM_W + 1;
    localparam int SUM_W     = TERM_W + 2;

    // derivative divider: magnitude of the difference scaled by 2^FRAC_BITS,
    // two quotient bits per cycle
    localparam int DIV_STEPS = (DATA_W + FRAC_BITS + 1) / 2;
    localparam int DIV_BITS  = 2 * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KI  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KD  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ILO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_IHI = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_DLO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_DHI = CFG_IDX_W'(7);

    // register reset values
    localparam logic signed [DATA_W-1:0] RST_GAIN = DATA_W'(0);
    localparam logic [DT_W-1:0]          RST_DT   = DT_W'(655);
    localparam logic signed [DATA_W-1:0] RST_ILO  = -DATA_W'(32768);
    localparam logic signed [DATA_W-1:0] RST_IHI  = DATA_W'(32768);
    localparam logic signed [DATA_W-1:0] RST_DLO  = -DATA_W'(65536);
    localparam logic signed [DATA_W-1:0] RST_DHI  = DATA_W'(65536);

    // command codes
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] target;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     drive_clamped;
    } t_out_item;

    // shared multiplier request
    typedef struct packed {
        logic                     en;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_mul_req;

    // divider request and status
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [DT_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic signed [DATA_W-1:0] quot;
    } t_div_stat;

    // saturate a 33-bit signed difference to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/pidc_mul.sv
module pidc_mul (
    input  logic                               i_clk,
    input  pidc_pkg::t_mul_req                 i_req,
    output logic signed [pidc_pkg::PROD_W-1:0] o_prod
);
    import pidc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // one signed 32x32 product, registered
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

### design/pidc_div.sv
module pidc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pidc_pkg::t_div_req  i_req,
    output pidc_pkg::t_div_stat o_stat
);
    import pidc_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [DT_W-1:0]      r_dvs;
    logic [DT_W-1:0]      r_rem;
    logic [DIV_BITS-1:0]  r_quo;

    logic [DT_W-1:0]      n_rem;
    logic [DIV_BITS-1:0]  n_quo;
    logic [DT_W:0]        trial;
    logic                 q_hi_zero;
    logic signed [DATA_W-1:0] quot;

    // two restoring steps per cycle, dividend bits shift out the top of r_quo
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[DIV_BITS-1]};
            n_quo = {n_quo[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem    = DT_W'(trial - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[DT_W-1:0];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != DIV_CNT_W'(1));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.neg;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= DIV_BITS'(i_req.mag) << FRAC_BITS;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // sign and saturate the magnitude quotient
    always_comb begin
        q_hi_zero = (r_quo[DIV_BITS-1:DATA_W-1] == '0);
        if (r_neg) begin
            quot = q_hi_zero ? -signed'(r_quo[DATA_W-1:0]) : {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            quot = q_hi_zero ? signed'(r_quo[DATA_W-1:0]) : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quot = quot;

endmodule

### design/pid_clamped_controller.sv
// PID regulator in signed fixed point (FRAC_BITS fraction bits, Q16.16 by default).
// Each input beat either runs one control step on a measurement and a setpoint or
// clears the integral and previous error; every input beat gives exactly one output
// beat. A clear goes straight to the S_OUT state. In a control step one 32x32 multiplier
// is shared by the four products in turn, and the derivative quotient comes from a
// restoring divider that produces two bits per cycle. With a zero sample period the
// divider is skipped and the derivative is zero. The input stalls while a step is in
// progress; a finished result sits in the output register and the block accepts the
// next beat while it waits. A result that finishes while the previous one is still
// held in the output register waits, with the input stalled, until that one is taken.
// The gains, sample period and limits are to be written through the configuration
// port only while the block is idle; the block itself does not enforce this.
module pid_clamped_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pidc_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pidc_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]        i_cfg_data
);
    import pidc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_INTEG = 4'd2;
    localparam logic [3:0] S_PKI   = 4'd3;
    localparam logic [3:0] S_ADDI  = 4'd4;
    localparam logic [3:0] S_WAITD = 4'd5;
    localparam logic [3:0] S_KD    = 4'd6;
    localparam logic [3:0] S_ADDD  = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // configuration registers
    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_ilo, r_ihi, r_dlo, r_dhi;
    logic [DT_W-1:0]          r_dt;

    // controller state
    logic [3:0]               r_state, n_state;
    logic signed [DATA_W-1:0] r_acc, n_acc;
    logic signed [DATA_W-1:0] r_last, n_last;

    // working registers
    logic signed [DATA_W-1:0] r_err, n_err;
    logic signed [DATA_W-1:0] r_diff, n_diff;
    logic signed [DATA_W-1:0] r_deriv, n_deriv;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic signed [DATA_W-1:0] r_drive, n_drive;
    logic                     r_flag, n_flag;

    // output register
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_item, n_out_item;

    // shared multiplier and divider
    t_mul_req                 mul_req;
    logic signed [PROD_W-1:0] prod;
    t_div_req                 div_req;
    t_div_stat                div_stat;

    logic                     in_acc;
    logic                     out_free;
    logic                     dt_zero;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  term_ext;
    logic signed [INTEG_W-1:0] isum;
    logic signed [INTEG_W-1:0] ilo_ext, ihi_ext;
    logic signed [DATA_W-1:0] integ;
    logic signed [SUM_W-1:0]  dlo_ext, dhi_ext;

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign dt_zero     = (r_dt == '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= RST_GAIN;
            r_ki  <= RST_GAIN;
            r_kd  <= RST_GAIN;
            r_dt  <= RST_DT;
            r_ilo <= RST_ILO;
            r_ihi <= RST_IHI;
            r_dlo <= RST_DLO;
            r_dhi <= RST_DHI;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KP:  r_kp  <= i_cfg_data;
                REG_KI:  r_ki  <= i_cfg_data;
                REG_KD:  r_kd  <= i_cfg_data;
                REG_DT:  r_dt  <= i_cfg_data[DT_W-1:0];
                REG_ILO: r_ilo <= i_cfg_data;
                REG_IHI: r_ihi <= i_cfg_data;
                REG_DLO: r_dlo <= i_cfg_data;
                REG_DHI: r_dhi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scaled product term, sign-extended limits and clamped integral sum
    always_comb begin
        term     = prod[PROD_W-1:FRAC_BITS];
        term_ext = {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
        isum     = {{(INTEG_W-DATA_W){r_acc[DATA_W-1]}}, r_acc}
                 + {{(INTEG_W-TERM_W){term[TERM_W-1]}}, term};
        ilo_ext  = {{(INTEG_W-DATA_W){r_ilo[DATA_W-1]}}, r_ilo};
        ihi_ext  = {{(INTEG_W-DATA_W){r_ihi[DATA_W-1]}}, r_ihi};
        dlo_ext  = {{(SUM_W-DATA_W){r_dlo[DATA_W-1]}}, r_dlo};
        dhi_ext  = {{(SUM_W-DATA_W){r_dhi[DATA_W-1]}}, r_dhi};
        // integral clamp: high limit compared first, then low limit; if the limits cross, the low limit wins
        if (isum > ihi_ext) begin
            integ = (r_ihi < r_ilo) ? r_ilo : r_ihi;
        end else if (isum < ilo_ext) begin
            integ = r_ilo;
        end else begin
            integ = isum[DATA_W-1:0];
        end
    end

    // multiplier operand select
    always_comb begin
        mul_req.en = 1'b0;
        mul_req.a  = r_err;
        mul_req.b  = signed'({1'b0, r_dt});
        case (r_state)
            S_DIFF: begin
                mul_req.en = 1'b1;
            end
            S_INTEG: begin
                mul_req.en = 1'b1;
                mul_req.b  = r_kp;
            end
            S_PKI: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_acc;
                mul_req.b  = r_ki;
            end
            S_KD: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_deriv;
                mul_req.b  = r_kd;
            end
            default: ;
        endcase
    end

    // divider launch for the derivative
    always_comb begin
        div_req.start   = (r_state == S_INTEG) && !dt_zero;
        div_req.neg     = r_diff[DATA_W-1];
        div_req.mag     = r_diff[DATA_W-1] ? DATA_W'(-r_diff) : DATA_W'(r_diff);
        div_req.divisor = r_dt;
    end

    // sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_last      = r_last;
        n_err       = r_err;
        n_diff      = r_diff;
        n_deriv     = r_deriv;
        n_sum       = r_sum;
        n_drive     = r_drive;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.command == CMD_CLEAR) begin
                        n_acc   = '0;
                        n_last  = '0;
                        n_drive = '0;
                        n_flag  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_err   = sat_33({i_in_item.target[DATA_W-1], i_in_item.target}
                                       - {i_in_item.measured[DATA_W-1], i_in_item.measured});
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_diff  = sat_33({r_err[DATA_W-1], r_err} - {r_last[DATA_W-1], r_last});
                n_last  = r_err;
                n_state = S_INTEG;
            end
            S_INTEG: begin
                n_acc   = integ;
                n_state = S_PKI;
            end
            S_PKI: begin
                n_sum   = term_ext;
                n_state = S_ADDI;
            end
            S_ADDI: begin
                n_sum   = r_sum + term_ext;
                n_state = S_WAITD;
            end
            S_WAITD: begin
                if (dt_zero) begin
                    n_deriv = '0;
                    n_state = S_KD;
                end else if (!div_stat.busy) begin
                    n_deriv = div_stat.quot;
                    n_state = S_KD;
                end
            end
            S_KD: begin
                n_state = S_ADDD;
            end
            S_ADDD: begin
                n_sum   = r_sum + term_ext;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                // drive clamp: high limit compared first, then low limit; if the limits cross, the low limit wins
                if (r_sum > dhi_ext) begin
                    n_drive = (r_dhi < r_dlo) ? r_dlo : r_dhi;
                    n_flag  = 1'b1;
                end else if (r_sum < dlo_ext) begin
                    n_drive = r_dlo;
                    n_flag  = 1'b1;
                end else begin
                    n_drive = r_sum[DATA_W-1:0];
                    n_flag  = 1'b0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_item.drive         = r_drive;
                    n_out_item.drive_clamped = r_flag;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_err      <= n_err;
        r_diff     <= n_diff;
        r_deriv    <= n_deriv;
        r_sum      <= n_sum;
        r_drive    <= n_drive;
        r_flag     <= n_flag;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a clear beat zeroes the integral and the previous error
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.command == CMD_CLEAR) |=> (r_acc == '0 && r_last == '0))
        else $error("clear did not zero controller state");

    // the divider is never relaunched while it is still working
    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a finished result waits while the output register is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result left while output register was held");

endmodule
